[src/bed_pkg.sv]
// Shared types and constants for the button and encoder debouncer.
`default_nettype none
package bed_pkg;

    localparam int COUNT_LIMIT_DEF = 500;
    localparam int NUM_CHAN        = 7;
    localparam int NUM_BUTTONS     = 6;
    localparam int ENC_CHAN        = 6;

    localparam int WAIT_W    = 9;
    localparam int CHAN_W    = 3;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [WAIT_W-1:0] BUTTON_WAIT_RST  = 9'd1;
    localparam logic [WAIT_W-1:0] ENCODER_WAIT_RST = 9'd3;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_WAIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_WAIT = 1'd1;

    typedef enum logic [EVENT_W-1:0] {
        ENC_NONE = 2'd0,
        ENC_CW   = 2'd1,
        ENC_CCW  = 2'd2
    } t_enc_event;

    typedef struct packed {
        logic edge_hit;
        logic tick;
    } t_chan_ctl;

endpackage
`default_nettype wire

[src/bed_req_if.sv]
// Request channel carrying one edge or tick item.
`default_nettype none
interface bed_req_if import bed_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [CHAN_W-1:0]      channel;
    logic [NUM_BUTTONS-1:0] button_levels;
    logic                   enc_a;
    logic                   enc_b;

    modport source (output valid, kind, channel, button_levels, enc_a, enc_b,
                    input ready);
    modport sink   (input valid, kind, channel, button_levels, enc_a, enc_b,
                    output ready);
endinterface
`default_nettype wire

[src/bed_rsp_if.sv]
// Result channel carrying the events reported for one request.
`default_nettype none
interface bed_rsp_if import bed_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [EVENT_W-1:0]     enc_event;
    logic [NUM_BUTTONS-1:0] pushed_mask;
    logic [NUM_BUTTONS-1:0] released_mask;

    modport source (output valid, enc_event, pushed_mask, released_mask,
                    input ready);
    modport sink   (input valid, enc_event, pushed_mask, released_mask,
                    output ready);
endinterface
`default_nettype wire

[src/bed_chan.sv]
// Settle counter and pending flag for one debounced channel.
`default_nettype none
module bed_chan import bed_pkg::*; #(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_chan_ctl         i_ctl,
    input  wire logic [WAIT_W-1:0] i_wait,
    output logic                   o_fire
);

    localparam int CW = $clog2(COUNT_LIMIT + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_pending, n_pending;
    logic [CW-1:0] count_inc;

    // The counter saturates so that a long quiet period cannot wrap it.
    assign count_inc = (r_count < CW'(COUNT_LIMIT)) ? r_count + CW'(1) : r_count;
    assign o_fire    = i_ctl.tick && r_pending && (WAIT_W'(count_inc) > i_wait);

    always_comb begin
        n_count   = r_count;
        n_pending = r_pending;
        if (i_ctl.edge_hit && !r_pending) begin
            n_count   = '0;
            n_pending = 1'b1;
        end else if (i_ctl.tick) begin
            n_count = count_inc;
            if (o_fire) begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end

endmodule
`default_nettype wire

[src/button_encoder_debounce.sv]
// Debouncer for six push buttons and one rotary-encoder channel.
// A result is held in the output register from the cycle after its request is taken.
// Throughput: one request per cycle; channel state updates in the accepting cycle.
// A request is taken while the output register is empty or being drained.
// Synchronous active-low reset clears all counters and pending flags,
// loads the default waits, and empties the output register.
`default_nettype none
module button_encoder_debounce import bed_pkg::*; #(
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WAIT_W-1:0]    i_cfg_data,
    bed_req_if.sink                   i_req,
    bed_rsp_if.source                 o_rsp
);

    logic [WAIT_W-1:0]      r_button_wait;
    logic [WAIT_W-1:0]      r_encoder_wait;
    logic                   r_out_valid;
    t_enc_event             r_enc_event, n_enc_event;
    logic [NUM_BUTTONS-1:0] r_pushed, r_released;

    logic                   accept;
    logic                   is_tick;
    logic [NUM_CHAN-1:0]    fire;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_tick     = (i_req.kind == KIND_TICK);

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
        t_chan_ctl ctl;
        assign ctl.edge_hit = accept && !is_tick && (i_req.channel == CHAN_W'(g));
        assign ctl.tick     = accept && is_tick;

        bed_chan #(
            .COUNT_LIMIT(COUNT_LIMIT)
        ) u_chan (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_wait ((g == ENC_CHAN) ? r_encoder_wait : r_button_wait),
            .o_fire (fire[g])
        );
    end

    always_comb begin
        if (!fire[ENC_CHAN]) begin
            n_enc_event = ENC_NONE;
        end else if (i_req.enc_a == i_req.enc_b) begin
            n_enc_event = ENC_CW;
        end else begin
            n_enc_event = ENC_CCW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_wait  <= BUTTON_WAIT_RST;
            r_encoder_wait <= ENCODER_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BUTTON_WAIT:  r_button_wait  <= i_cfg_data;
                REG_ENCODER_WAIT: r_encoder_wait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Masks come out zero on edge requests because no channel fires then.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_enc_event <= n_enc_event;
            r_pushed    <= fire[NUM_BUTTONS-1:0] & ~i_req.button_levels;
            r_released  <= fire[NUM_BUTTONS-1:0] & i_req.button_levels;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.enc_event     = r_enc_event;
    assign o_rsp.pushed_mask   = r_pushed;
    assign o_rsp.released_mask = r_released;

endmodule
`default_nettype wire
